// ===== hdl/ccpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types and codes for the constant pool parser.
// ----------------------------------------------------------------------------
package ccpp_pkg;

   // parse phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_COUNT_LO = 4'd1,
      PH_TAG      = 4'd2,
      PH_LEN_HI   = 4'd3,
      PH_LEN_LO   = 4'd4,
      PH_TEXT     = 4'd5,
      PH_INT      = 4'd6,
      PH_REF1_HI  = 4'd7,
      PH_REF1_LO  = 4'd8,
      PH_REF2_HI  = 4'd9,
      PH_REF2_LO  = 4'd10,
      PH_HALTED   = 4'd11
   } phase_type;

   // entry kinds as reported on entry_kind
   typedef enum logic [2:0] {
      KIND_UTF8      = 3'd0,
      KIND_INTEGER   = 3'd1,
      KIND_STRING    = 3'd2,
      KIND_CLASS     = 3'd3,
      KIND_FIELDREF  = 3'd4,
      KIND_METHODREF = 3'd5,
      KIND_NAME_TYPE = 3'd6
   } kind_type;

   // tag byte codes of the class file format
   localparam logic [7:0] TAG_UTF8      = 8'd1;
   localparam logic [7:0] TAG_INTEGER   = 8'd3;
   localparam logic [7:0] TAG_CLASS     = 8'd7;
   localparam logic [7:0] TAG_STRING    = 8'd8;
   localparam logic [7:0] TAG_FIELDREF  = 8'd9;
   localparam logic [7:0] TAG_METHODREF = 8'd10;
   localparam logic [7:0] TAG_NAME_TYPE = 8'd12;

   localparam logic [2:0]  INT_BYTES = 3'd4;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // one result
   typedef struct packed {
      logic [15:0] entry_number;
      logic [2:0]  entry_kind;
      logic [15:0] first_reference;
      logic [15:0] second_reference;
      logic [31:0] integer_value;
      logic [7:0]  text_byte;
      logic        text_valid;
      logic        entry_done;
      logic        pool_done;
      logic [31:0] pool_byte_count;
      logic        error_code;
   } result_type;

endpackage

// ===== hdl/ccpp_parser.sv =====
// ----------------------------------------------------------------------------
// ccpp_parser
// Byte-at-a-time parse state and result generation for one accepted request.
// ----------------------------------------------------------------------------
module ccpp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  logic [7:0]             in_byte,
   input  logic                   in_start,
   output logic                   res_valid,
   output ccpp_pkg::result_type   res
);

   ccpp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] entry_ff, entry_in;
   logic [15:0] remain_ff, remain_in;
   logic [31:0] shift_ff, shift_in;
   logic [15:0] held_ff, held_in;
   ccpp_pkg::kind_type kind_ff, kind_in;
   logic [31:0] consumed_ff, consumed_in;

   logic [31:0] consumed_inc;
   logic [15:0] word16;
   logic [15:0] remain_dec;
   logic        last_entry;
   logic        active;

   assign active       = (phase_ff != ccpp_pkg::PH_IDLE) && (phase_ff != ccpp_pkg::PH_HALTED);
   assign consumed_inc = (consumed_ff == ccpp_pkg::COUNT_MAX) ? consumed_ff
                                                              : consumed_ff + 32'd1;
   assign word16       = {shift_ff[7:0], in_byte};
   assign remain_dec   = remain_ff - 16'd1;
   assign last_entry   = ({1'b0, entry_ff} + 17'd1) >= {1'b0, total_ff};

   // next state
   always_comb begin
      phase_in    = phase_ff;
      total_in    = total_ff;
      entry_in    = entry_ff;
      remain_in   = remain_ff;
      shift_in    = shift_ff;
      held_in     = held_ff;
      kind_in     = kind_ff;
      consumed_in = consumed_ff;
      if (in_fire && in_start) begin
         phase_in    = ccpp_pkg::PH_COUNT_LO;
         shift_in    = {24'd0, in_byte};
         consumed_in = 32'd1;
         total_in    = '0;
         entry_in    = '0;
         remain_in   = '0;
         held_in     = '0;
         kind_in     = ccpp_pkg::KIND_UTF8;
      end else if (in_fire && active) begin
         consumed_in = consumed_inc;
         unique case (phase_ff)
            ccpp_pkg::PH_COUNT_LO: begin
               total_in = word16;
               shift_in = '0;
               if (word16 <= 16'd1) begin
                  phase_in = ccpp_pkg::PH_IDLE;
               end else begin
                  entry_in = 16'd1;
                  phase_in = ccpp_pkg::PH_TAG;
               end
            end
            ccpp_pkg::PH_TAG: begin
               shift_in = '0;
               held_in  = '0;
               unique case (in_byte)
                  ccpp_pkg::TAG_UTF8: begin
                     kind_in  = ccpp_pkg::KIND_UTF8;
                     phase_in = ccpp_pkg::PH_LEN_HI;
                  end
                  ccpp_pkg::TAG_INTEGER: begin
                     kind_in   = ccpp_pkg::KIND_INTEGER;
                     remain_in = {13'd0, ccpp_pkg::INT_BYTES};
                     phase_in  = ccpp_pkg::PH_INT;
                  end
                  ccpp_pkg::TAG_STRING: begin
                     kind_in  = ccpp_pkg::KIND_STRING;
                     phase_in = ccpp_pkg::PH_REF1_HI;
                  end
                  ccpp_pkg::TAG_CLASS: begin
                     kind_in  = ccpp_pkg::KIND_CLASS;
                     phase_in = ccpp_pkg::PH_REF1_HI;
                  end
                  ccpp_pkg::TAG_FIELDREF: begin
                     kind_in  = ccpp_pkg::KIND_FIELDREF;
                     phase_in = ccpp_pkg::PH_REF1_HI;
                  end
                  ccpp_pkg::TAG_METHODREF: begin
                     kind_in  = ccpp_pkg::KIND_METHODREF;
                     phase_in = ccpp_pkg::PH_REF1_HI;
                  end
                  ccpp_pkg::TAG_NAME_TYPE: begin
                     kind_in  = ccpp_pkg::KIND_NAME_TYPE;
                     phase_in = ccpp_pkg::PH_REF1_HI;
                  end
                  default: begin
                     kind_in  = ccpp_pkg::KIND_UTF8;
                     phase_in = ccpp_pkg::PH_HALTED;
                  end
               endcase
            end
            ccpp_pkg::PH_LEN_HI, ccpp_pkg::PH_REF1_HI, ccpp_pkg::PH_REF2_HI: begin
               shift_in = {24'd0, in_byte};
               unique case (phase_ff)
                  ccpp_pkg::PH_LEN_HI:  phase_in = ccpp_pkg::PH_LEN_LO;
                  ccpp_pkg::PH_REF1_HI: phase_in = ccpp_pkg::PH_REF1_LO;
                  default:              phase_in = ccpp_pkg::PH_REF2_LO;
               endcase
            end
            ccpp_pkg::PH_LEN_LO: begin
               remain_in = word16;
               shift_in  = '0;
               if (word16 != 16'd0) begin
                  phase_in = ccpp_pkg::PH_TEXT;
               end
            end
            ccpp_pkg::PH_TEXT: begin
               remain_in = remain_dec;
            end
            ccpp_pkg::PH_INT: begin
               shift_in  = {shift_ff[23:0], in_byte};
               remain_in = remain_dec;
            end
            ccpp_pkg::PH_REF1_LO: begin
               held_in  = word16;
               shift_in = '0;
               if (kind_ff != ccpp_pkg::KIND_STRING && kind_ff != ccpp_pkg::KIND_CLASS) begin
                  phase_in = ccpp_pkg::PH_REF2_HI;
               end
            end
            default: ;  // PH_REF2_LO: only completes the entry
         endcase
         // entry completion moves on to the next tag or back to idle
         if (res_valid && res.entry_done) begin
            if (last_entry) begin
               phase_in = ccpp_pkg::PH_IDLE;
            end else begin
               entry_in = entry_ff + 16'd1;
               phase_in = ccpp_pkg::PH_TAG;
            end
         end
      end
   end

   // result
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      if (in_fire && !in_start && active) begin
         unique case (phase_ff)
            ccpp_pkg::PH_COUNT_LO: begin
               if (word16 <= 16'd1) begin
                  res_valid           = 1'b1;
                  res.pool_done       = 1'b1;
                  res.pool_byte_count = consumed_inc;
               end
            end
            ccpp_pkg::PH_TAG: begin
               if (in_byte != ccpp_pkg::TAG_UTF8 && in_byte != ccpp_pkg::TAG_INTEGER &&
                   in_byte != ccpp_pkg::TAG_STRING && in_byte != ccpp_pkg::TAG_CLASS &&
                   in_byte != ccpp_pkg::TAG_FIELDREF && in_byte != ccpp_pkg::TAG_METHODREF &&
                   in_byte != ccpp_pkg::TAG_NAME_TYPE) begin
                  res_valid        = 1'b1;
                  res.entry_number = entry_ff;
                  res.error_code   = 1'b1;
               end
            end
            ccpp_pkg::PH_LEN_LO: begin
               res.entry_done = 1'b1;
               res_valid      = (word16 == 16'd0);
            end
            ccpp_pkg::PH_TEXT: begin
               res_valid      = 1'b1;
               res.text_byte  = in_byte;
               res.text_valid = 1'b1;
               res.entry_done = (remain_dec == 16'd0);
            end
            ccpp_pkg::PH_INT: begin
               res.integer_value = {shift_ff[23:0], in_byte};
               res.entry_done    = 1'b1;
               res_valid         = (remain_dec == 16'd0);
            end
            ccpp_pkg::PH_REF1_LO: begin
               res.first_reference = word16;
               res.entry_done      = 1'b1;
               res_valid = (kind_ff == ccpp_pkg::KIND_STRING) || (kind_ff == ccpp_pkg::KIND_CLASS);
            end
            ccpp_pkg::PH_REF2_LO: begin
               res.first_reference  = held_ff;
               res.second_reference = word16;
               res.entry_done       = 1'b1;
               res_valid            = 1'b1;
            end
            default: ;
         endcase
         if (res_valid && res.entry_done) begin
            res.entry_number = entry_ff;
            res.entry_kind   = kind_ff;
            res.pool_done    = last_entry;
            res.pool_byte_count = last_entry ? consumed_inc : 32'd0;
         end else if (res_valid && res.text_valid) begin
            res.entry_number = entry_ff;
            res.entry_kind   = kind_ff;
         end
         if (!res_valid) begin
            res = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ccpp_pkg::PH_IDLE;
         total_ff    <= '0;
         entry_ff    <= '0;
         remain_ff   <= '0;
         shift_ff    <= '0;
         held_ff     <= '0;
         kind_ff     <= ccpp_pkg::KIND_UTF8;
         consumed_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         total_ff    <= total_in;
         entry_ff    <= entry_in;
         remain_ff   <= remain_in;
         shift_ff    <= shift_in;
         held_ff     <= held_in;
         kind_ff     <= kind_in;
         consumed_ff <= consumed_in;
      end
   end

endmodule

// ===== hdl/ccpp_out_buf.sv =====
// ----------------------------------------------------------------------------
// ccpp_out_buf
// Two-entry result register with skid slot; ready is decoded from the registered count.
// ----------------------------------------------------------------------------
module ccpp_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ccpp_pkg::result_type   push_data,
   output logic                   can_take,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ccpp_pkg::result_type   out_data
);

   logic [1:0] count_ff, count_in;
   ccpp_pkg::result_type slot0_ff, slot0_in;
   ccpp_pkg::result_type slot1_ff, slot1_in;
   logic pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign can_take  = (count_ff != 2'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      unique case (count_ff)
         2'd0: begin
            if (push) slot0_in = push_data;
         end
         2'd1: begin
            if (push && pop) slot0_in = push_data;
            else if (push)   slot1_in = push_data;
         end
         default: begin
            if (pop) begin
               slot0_in = slot1_ff;
               if (push) slot1_in = push_data;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== hdl/class_constant_pool_parser.sv =====
// ----------------------------------------------------------------------------
// class_constant_pool_parser
// Streaming parser for a class-file constant pool, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): one pool byte per request, with
//   req_start_pool set on the first of the two big-endian count bytes.
//   Response channel (rsp_valid/rsp_ready): one response per text byte of a
//   utf8 entry, one per completed non-text entry, one on an unsupported tag
//   (then bytes are dropped until the next start), one for an empty pool.
//   rsp_pool_done with rsp_pool_byte_count marks the end of the pool; the
//   count includes the two count bytes and saturates at all ones.
// Timing: the response to a request is registered in the response buffer.
// Throughput: one byte per cycle while req_ready is high; parse state and
//   response are computed combinationally from the state registers.
// Stall: the response side has a two-entry buffer; requests keep being taken
//   while a response waits, until both entries hold, then req_ready drops.
// Reset: synchronous; the parser returns to idle, waiting for a start byte,
//   and the response buffer empties.
// ----------------------------------------------------------------------------
module class_constant_pool_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_pool,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_entry_number,
   output logic [2:0]  rsp_entry_kind,
   output logic [15:0] rsp_first_reference,
   output logic [15:0] rsp_second_reference,
   output logic signed [31:0] rsp_integer_value,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_text_valid,
   output logic        rsp_entry_done,
   output logic        rsp_pool_done,
   output logic [31:0] rsp_pool_byte_count,
   output logic        rsp_error_code
);

   logic                 req_fire;
   logic                 res_valid;
   ccpp_pkg::result_type res;
   ccpp_pkg::result_type rsp;

   // request taken whenever the response buffer has a free entry
   assign req_fire = req_valid && req_ready;

   ccpp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (req_fire),
      .in_byte   (req_data_byte),
      .in_start  (req_start_pool),
      .res_valid (res_valid),
      .res       (res)
   );

   ccpp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_take  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp)
   );

   assign rsp_entry_number     = rsp.entry_number;
   assign rsp_entry_kind       = rsp.entry_kind;
   assign rsp_first_reference  = rsp.first_reference;
   assign rsp_second_reference = rsp.second_reference;
   assign rsp_integer_value    = signed'(rsp.integer_value);
   assign rsp_text_byte        = rsp.text_byte;
   assign rsp_text_valid       = rsp.text_valid;
   assign rsp_entry_done       = rsp.entry_done;
   assign rsp_pool_done        = rsp.pool_done;
   assign rsp_pool_byte_count  = rsp.pool_byte_count;
   assign rsp_error_code       = rsp.error_code;

endmodule

// ===== hdl/ccpp_checker.sv =====
// ----------------------------------------------------------------------------
// ccpp_checker
// Port-level checks on the constant pool parser, bound to the top level.
// ----------------------------------------------------------------------------
module ccpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_entry_number,
   input logic [2:0]  rsp_entry_kind,
   input logic [15:0] rsp_first_reference,
   input logic [15:0] rsp_second_reference,
   input logic signed [31:0] rsp_integer_value,
   input logic [7:0]  rsp_text_byte,
   input logic        rsp_text_valid,
   input logic        rsp_entry_done,
   input logic        rsp_pool_done,
   input logic [31:0] rsp_pool_byte_count,
   input logic        rsp_error_code
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_number)
         && $stable(rsp_entry_kind) && $stable(rsp_first_reference)
         && $stable(rsp_second_reference) && $stable(rsp_integer_value)
         && $stable(rsp_text_byte) && $stable(rsp_text_valid)
         && $stable(rsp_entry_done) && $stable(rsp_pool_done)
         && $stable(rsp_pool_byte_count) && $stable(rsp_error_code))
      else $error("stalled response changed");

   // text responses belong to utf8 entries and carry no error
   a_text_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_valid |-> !rsp_error_code
         && rsp_entry_kind == ccpp_pkg::KIND_UTF8)
      else $error("text response with bad kind or error");

   // error responses never complete an entry or the pool
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code |-> !rsp_entry_done && !rsp_pool_done)
      else $error("error response marked done");

   // byte count only shown with pool end
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pool_done |-> rsp_pool_byte_count == 32'd0)
      else $error("byte count outside pool end");

   // reset empties the response side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending after reset");

endmodule

bind class_constant_pool_parser ccpp_checker u_ccpp_checker (.*);
